@@ rtl/ptt_pkg.sv @@
// Shared types, field widths and codes of the periodic timer table.
// Used by every module of the block; depends on nothing.
package ptt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  // Depth of the command queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;

  localparam int OP_W = 3;
  localparam int SLOT_W = 4;
  localparam int INTERVAL_W = 32;
  localparam int KIND_W = 2;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_TICK = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD = 3'd1;
  localparam logic [OP_W-1:0] OP_CHANGE = 3'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  localparam logic [KIND_W-1:0] KIND_FIRED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic [SLOT_W-1:0] slot;
    logic [OP_W-1:0] op;
  } cmd_t;

endpackage

@@ rtl/periodic_timer_table_top.sv @@
// Periodic timer table: a bank of NUM_SLOTS periodic timers with a
// TIME_BITS-wide tick counter. A tick word advances time and then
// reports every timer that is due, one word per fired slot in slot order,
// with tlast on the final one and nothing at all when none is due. Add,
// change interval, restart and remove each answer with one word. The back
// end runs one command at a time. A tick scans the slots, reading one slot
// per cycle from the interval and start-time memories through a read
// register unless output backpressure holds the scan; an add searches for
// the lowest free slot. A two-word command queue lets the input accept
// while a command runs, and output backpressure stalls the back end only.
// Depends on ptt_pkg, ptt_front and ptt_back.
module periodic_timer_table_top #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // op [2:0], slot [6:3], interval [38:7], zero [39]
  input  logic [ptt_pkg::IN_DATA_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // kind [1:0], slot_out [5:2], status [7:6]
  output logic [ptt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic m_tlast
);

  logic q_valid;
  logic q_pop;
  ptt_pkg::cmd_t q_data;

  ptt_front u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .q_valid(q_valid),
    .q_data(q_data),
    .q_pop(q_pop)
  );

  ptt_back #(
    .NUM_SLOTS(NUM_SLOTS),
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(q_data),
    .q_pop(q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("Command taken from an empty queue.");

  a_answer_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ptt_pkg::KIND_FIRED) |-> m_tlast)
    else $error("Command answer without tlast.");

  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == ptt_pkg::KIND_FIRED) |-> (m_tdata[7:6] == ptt_pkg::ST_OK))
    else $error("Fired timer word with a nonzero status.");
`endif

endmodule

@@ rtl/ptt_front.sv @@
// Front end of the periodic timer table: accepts input words, drops unknown
// operations and holds the rest in a short command queue.
// Depends on ptt_pkg.
module ptt_front (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // op [2:0], slot [6:3], interval [38:7], zero [39]
  input  logic [ptt_pkg::IN_DATA_W-1:0] s_tdata,
  output logic q_valid,
  output ptt_pkg::cmd_t q_data,
  input  logic q_pop
);

  localparam int Depth = ptt_pkg::QUEUE_DEPTH;
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam int SlotLo = ptt_pkg::OP_W;
  localparam int IvalLo = ptt_pkg::OP_W + ptt_pkg::SLOT_W;

  ptt_pkg::cmd_t queue_mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [ptt_pkg::OP_W-1:0] op;
  logic known;
  logic push;

  assign op = s_tdata[ptt_pkg::OP_W-1:0];
  assign known = (op == ptt_pkg::OP_TICK) || (op == ptt_pkg::OP_ADD) ||
                 (op == ptt_pkg::OP_CHANGE) || (op == ptt_pkg::OP_RESTART) ||
                 (op == ptt_pkg::OP_REMOVE);
  assign s_tready = (count != CntW'(Depth));
  assign push = s_tvalid && s_tready && known;
  assign q_valid = (count != '0);
  assign q_data = queue_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr].op <= op;
      queue_mem[wr_ptr].slot <= s_tdata[SlotLo +: ptt_pkg::SLOT_W];
      queue_mem[wr_ptr].interval <= s_tdata[IvalLo +: ptt_pkg::INTERVAL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      case ({push, q_pop})
        2'b10: count <= count + CntW'(1);
        2'b01: count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/ptt_back.sv @@
// Back end of the periodic timer table: time counter, slot memories, the
// tick scan, the command sequencer and the output register.
// Depends on ptt_pkg.
module ptt_back #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  ptt_pkg::cmd_t q_data,
  output logic q_pop,
  output logic m_tvalid,
  input  logic m_tready,
  // kind [1:0], slot_out [5:2], status [7:6]
  output logic [ptt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic m_tlast
);

  localparam int IdxW = $clog2(NUM_SLOTS);
  localparam int CntW = $clog2(NUM_SLOTS + 1);
  localparam int ExtW = (TIME_BITS > ptt_pkg::INTERVAL_W) ? TIME_BITS : ptt_pkg::INTERVAL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TICK = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_ADD = 3'd3;
  localparam logic [2:0] S_CMD = 3'd4;

  logic [TIME_BITS-1:0] ival_mem [NUM_SLOTS];
  logic [TIME_BITS-1:0] start_mem [NUM_SLOTS];

  logic [2:0] state;
  ptt_pkg::cmd_t cmd;
  logic [TIME_BITS-1:0] now;
  logic [NUM_SLOTS-1:0] valid;
  logic [CntW-1:0] cnt;
  logic ev_vld;
  logic [IdxW-1:0] ev_idx;
  logic [TIME_BITS-1:0] ival_q;
  logic [TIME_BITS-1:0] start_q;
  logic pend_vld;
  logic [IdxW-1:0] pend_slot;

  logic [ptt_pkg::KIND_W-1:0] kind;
  logic [ptt_pkg::SLOT_W-1:0] slot_out;
  logic [ptt_pkg::STATUS_W-1:0] status;
  logic last;

  logic out_can;
  logic [IdxW-1:0] scan_idx;
  logic scan_done;
  logic [TIME_BITS-1:0] elapsed;
  logic ev_fire;
  logic tick_adv;
  logic [IdxW-1:0] cmd_idx;
  logic cmd_hit;
  logic [ExtW-1:0] ival_ext;
  logic [TIME_BITS-1:0] cmd_ival;

  logic emit;
  logic [ptt_pkg::KIND_W-1:0] e_kind;
  logic [ptt_pkg::SLOT_W-1:0] e_slot;
  logic [ptt_pkg::STATUS_W-1:0] e_status;
  logic e_last;
  logic st_we;
  logic [IdxW-1:0] st_waddr;
  logic [TIME_BITS-1:0] st_wdata;
  logic iv_we;
  logic [IdxW-1:0] iv_waddr;
  logic rd_en;

  assign out_can = !m_tvalid || m_tready;
  assign scan_idx = cnt[IdxW-1:0];
  assign scan_done = (cnt == CntW'(NUM_SLOTS));
  assign elapsed = now - start_q;
  assign ev_fire = ev_vld && valid[ev_idx] && (elapsed > ival_q);
  assign tick_adv = !(ev_fire && pend_vld && !out_can);
  assign cmd_idx = IdxW'(cmd.slot);
  assign cmd_hit = (32'(cmd.slot) < 32'(NUM_SLOTS)) && valid[cmd_idx];
  assign ival_ext = ExtW'(cmd.interval);
  assign cmd_ival = ival_ext[TIME_BITS-1:0];
  assign rd_en = (state == S_TICK) && tick_adv && !scan_done;

  assign m_tdata = {status, slot_out, kind};
  assign m_tlast = last;

  always_comb begin
    q_pop = 1'b0;
    emit = 1'b0;
    e_kind = ptt_pkg::KIND_FIRED;
    e_slot = '0;
    e_status = ptt_pkg::ST_OK;
    e_last = 1'b1;
    st_we = 1'b0;
    st_waddr = cmd_idx;
    st_wdata = now;
    iv_we = 1'b0;
    iv_waddr = cmd_idx;
    case (state)
      S_IDLE: begin
        q_pop = q_valid;
      end
      S_TICK: begin
        if (tick_adv && ev_fire) begin
          st_we = 1'b1;
          st_waddr = ev_idx;
          st_wdata = start_q + ival_q;
          if (pend_vld) begin
            emit = 1'b1;
            e_slot = ptt_pkg::SLOT_W'(pend_slot);
            e_last = 1'b0;
          end
        end
      end
      S_FLUSH: begin
        if (pend_vld && out_can) begin
          emit = 1'b1;
          e_slot = ptt_pkg::SLOT_W'(pend_slot);
        end
      end
      S_ADD: begin
        if (scan_done) begin
          if (out_can) begin
            emit = 1'b1;
            e_kind = ptt_pkg::KIND_ADD;
            e_status = ptt_pkg::ST_FULL;
          end
        end else if (!valid[scan_idx] && out_can) begin
          emit = 1'b1;
          e_kind = ptt_pkg::KIND_ADD;
          e_slot = ptt_pkg::SLOT_W'(scan_idx);
          st_we = 1'b1;
          st_waddr = scan_idx;
          iv_we = 1'b1;
          iv_waddr = scan_idx;
        end
      end
      S_CMD: begin
        if (out_can) begin
          emit = 1'b1;
          e_kind = ptt_pkg::KIND_STATUS;
          e_slot = cmd.slot;
          e_status = cmd_hit ? ptt_pkg::ST_OK : ptt_pkg::ST_NOT_FOUND;
          iv_we = cmd_hit && (cmd.op == ptt_pkg::OP_CHANGE);
          st_we = cmd_hit && (cmd.op == ptt_pkg::OP_RESTART);
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (iv_we) begin
      ival_mem[iv_waddr] <= cmd_ival;
    end
    if (st_we) begin
      start_mem[st_waddr] <= st_wdata;
    end
    if (rd_en) begin
      ival_q <= ival_mem[scan_idx];
      start_q <= start_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind <= e_kind;
      slot_out <= e_slot;
      status <= e_status;
      last <= e_last;
    end
    if (q_pop) begin
      cmd <= q_data;
    end
    if (rst) begin
      state <= S_IDLE;
      now <= '0;
      valid <= '0;
      cnt <= '0;
      ev_vld <= 1'b0;
      ev_idx <= '0;
      pend_vld <= 1'b0;
      pend_slot <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cnt <= '0;
          ev_vld <= 1'b0;
          pend_vld <= 1'b0;
          if (q_valid) begin
            case (q_data.op)
              ptt_pkg::OP_TICK: begin
                now <= now + TIME_BITS'(1);
                state <= S_TICK;
              end
              ptt_pkg::OP_ADD: state <= S_ADD;
              default: state <= S_CMD;
            endcase
          end
        end
        S_TICK: begin
          if (tick_adv) begin
            if (ev_fire) begin
              pend_vld <= 1'b1;
              pend_slot <= ev_idx;
            end
            ev_vld <= !scan_done;
            ev_idx <= scan_idx;
            if (scan_done) begin
              state <= S_FLUSH;
            end else begin
              cnt <= cnt + CntW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_vld || out_can) begin
            pend_vld <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_ADD: begin
          if (scan_done) begin
            if (out_can) begin
              state <= S_IDLE;
            end
          end else if (!valid[scan_idx]) begin
            if (out_can) begin
              valid[scan_idx] <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            cnt <= cnt + CntW'(1);
          end
        end
        S_CMD: begin
          if (out_can) begin
            if (cmd_hit && (cmd.op == ptt_pkg::OP_REMOVE)) begin
              valid[cmd_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
